// ===== design/mtxy_pkg.sv =====
// ----------------------------------------------------------------------------
// mtxy_pkg
// Shared constants and register indexes for the multiturn encoder xy tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mtxy_pkg;

	localparam int ENCODER_BITS_DEF = 14;
	localparam int TURN_BITS_DEF    = 16;

	localparam int DATA_W     = 32;
	localparam int GAIN_W     = 24;
	localparam int GAIN_SHIFT = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd7540000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_LEFT   = 2'd0,
		REG_OFFSET_RIGHT  = 2'd1,
		REG_POSITION_GAIN = 2'd2
	} cfg_reg_t;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== design/mtxy_track.sv =====
// ----------------------------------------------------------------------------
// mtxy_track
// Turn counting and unwrapped angle for one motor, with saturated angle register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtxy_track #(
	parameter int ENCODER_BITS = mtxy_pkg::ENCODER_BITS_DEF,
	parameter int TURN_BITS    = mtxy_pkg::TURN_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic [ENCODER_BITS-1:0]           raw,
	input  wire logic signed [mtxy_pkg::DATA_W-1:0] offset,
	output logic signed [mtxy_pkg::DATA_W-1:0]     angle_s2
);
	import mtxy_pkg::*;

	localparam int SUM_W = ((TURN_BITS + ENCODER_BITS > DATA_W) ?
		(TURN_BITS + ENCODER_BITS) : DATA_W) + 2;

	localparam logic [ENCODER_BITS-1:0] HALF = {1'b1, {(ENCODER_BITS-1){1'b0}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN =
		{1'b1, {(TURN_BITS-2){1'b0}}, 1'b1};
	localparam logic signed [TURN_BITS-1:0] TURN_ONE = TURN_BITS'(1);

	logic [ENCODER_BITS-1:0]        prev_q;
	logic signed [TURN_BITS-1:0]    turns_q;
	logic signed [TURN_BITS-1:0]    turns_nxt;
	logic [ENCODER_BITS-1:0]        diff_up;
	logic [ENCODER_BITS-1:0]        diff_dn;
	logic                           step_up;
	logic                           step_dn;
	logic signed [SUM_W-1:0]        sum;
	logic [SUM_W-DATA_W:0]          sum_hi;
	logic signed [DATA_W-1:0]       angle_sat;

	assign diff_up = raw - prev_q;
	assign diff_dn = prev_q - raw;
	assign step_up = (raw > prev_q) && (diff_up > HALF);
	assign step_dn = (prev_q > raw) && (diff_dn > HALF);

	always_comb begin
		turns_nxt = turns_q;
		if (step_up && (turns_q != TURN_MAX)) begin
			turns_nxt = turns_q + TURN_ONE;
		end else if (step_dn && (turns_q != TURN_MIN)) begin
			turns_nxt = turns_q - TURN_ONE;
		end
	end

	always_comb begin
		sum = (SUM_W'(turns_nxt) <<< ENCODER_BITS)
			- $signed(SUM_W'({1'b0, raw}))
			+ SUM_W'(offset);
		sum_hi = sum[SUM_W-1:DATA_W-1];
		if ((&sum_hi) || !(|sum_hi)) begin
			angle_sat = sum[DATA_W-1:0];
		end else if (sum[SUM_W-1]) begin
			angle_sat = SAT_MIN;
		end else begin
			angle_sat = SAT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			turns_q <= '0;
		end else if (load) begin
			prev_q  <= raw;
			turns_q <= turns_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			angle_s2 <= angle_sat;
		end
	end

endmodule

`default_nettype wire

// ===== design/mtxy_mix.sv =====
// ----------------------------------------------------------------------------
// mtxy_mix
// CoreXY mix of the two angles, gain multiply, floor shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mtxy_mix (
	input  wire logic                               clk,
	input  wire logic                               load,
	input  wire logic signed [mtxy_pkg::DATA_W-1:0] angle_left,
	input  wire logic signed [mtxy_pkg::DATA_W-1:0] angle_right,
	input  wire logic [mtxy_pkg::GAIN_W-1:0]        gain,
	output logic signed [mtxy_pkg::DATA_W-1:0]      pos_x_s3,
	output logic signed [mtxy_pkg::DATA_W-1:0]      pos_y_s3
);
	import mtxy_pkg::*;

	localparam int MIX_W  = DATA_W + 2;
	localparam int PROD_W = MIX_W + GAIN_W + 1;
	localparam int SH_W   = PROD_W - GAIN_SHIFT;

	logic signed [MIX_W-1:0]  dx;
	logic signed [MIX_W-1:0]  dy;
	logic signed [GAIN_W:0]   gain_s;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [SH_W-1:0]   sh_x;
	logic signed [SH_W-1:0]   sh_y;
	logic [SH_W-DATA_W:0]     hi_x;
	logic [SH_W-DATA_W:0]     hi_y;
	logic signed [DATA_W-1:0] sat_x;
	logic signed [DATA_W-1:0] sat_y;

	assign gain_s = $signed({1'b0, gain});
	assign dx     = MIX_W'(angle_left) - MIX_W'(angle_right);
	assign dy     = -MIX_W'(angle_left) - MIX_W'(angle_right);
	assign prod_x = PROD_W'(dx) * PROD_W'(gain_s);
	assign prod_y = PROD_W'(dy) * PROD_W'(gain_s);
	assign sh_x   = prod_x[PROD_W-1:GAIN_SHIFT];
	assign sh_y   = prod_y[PROD_W-1:GAIN_SHIFT];
	assign hi_x   = sh_x[SH_W-1:DATA_W-1];
	assign hi_y   = sh_y[SH_W-1:DATA_W-1];

	always_comb begin
		if ((&hi_x) || !(|hi_x)) begin
			sat_x = sh_x[DATA_W-1:0];
		end else if (sh_x[SH_W-1]) begin
			sat_x = SAT_MIN;
		end else begin
			sat_x = SAT_MAX;
		end
		if ((&hi_y) || !(|hi_y)) begin
			sat_y = sh_y[DATA_W-1:0];
		end else if (sh_y[SH_W-1]) begin
			sat_y = SAT_MIN;
		end else begin
			sat_y = SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_x_s3 <= sat_x;
			pos_y_s3 <= sat_y;
		end
	end

endmodule

`default_nettype wire

// ===== design/multiturn_encoder_xy_tracker.sv =====
// ----------------------------------------------------------------------------
// multiturn_encoder_xy_tracker
// Unwraps two absolute encoder readings into multiturn angles and gives the
// CoreXY position in Q15.16 meters.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready, one transfer carries raw_left and
//   raw_right. output channel: out_valid / out_ready, one transfer carries
//   angle_left, angle_right, pos_x and pos_y for each input transfer.
//   config port: cfg_wr_en, cfg_index, cfg_data; must be written by the user
//   while idle only; the block itself does not enforce this.
//   stages: an input transfer passes the input register, the turn tracking
//   stage and the multiply and saturate stage before out_valid rises.
//   throughput: one item per cycle while out_ready stays high; the gain
//   multiply stage is the longest path.
//   reset: clears turn counters, previous readings and all valid flags;
//   offsets reset to zero and the gain to its default.
//   stall: each stage holds while the next is full and not moving, so the
//   pipeline fills up to three items before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module multiturn_encoder_xy_tracker #(
	parameter int ENCODER_BITS = mtxy_pkg::ENCODER_BITS_DEF,
	parameter int TURN_BITS    = mtxy_pkg::TURN_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [mtxy_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mtxy_pkg::DATA_W-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [ENCODER_BITS-1:0]            raw_left,
	input  wire logic [ENCODER_BITS-1:0]            raw_right,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [mtxy_pkg::DATA_W-1:0]      angle_left,
	output logic signed [mtxy_pkg::DATA_W-1:0]      angle_right,
	output logic signed [mtxy_pkg::DATA_W-1:0]      pos_x,
	output logic signed [mtxy_pkg::DATA_W-1:0]      pos_y
);
	import mtxy_pkg::*;

	logic signed [DATA_W-1:0] offset_left_q;
	logic signed [DATA_W-1:0] offset_right_q;
	logic [GAIN_W-1:0]        gain_q;

	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic                     adv_s1;
	logic                     adv_s2;
	logic                     adv_s3;
	logic [ENCODER_BITS-1:0]  raw_left_s1;
	logic [ENCODER_BITS-1:0]  raw_right_s1;
	logic signed [DATA_W-1:0] angle_left_s2;
	logic signed [DATA_W-1:0] angle_right_s2;
	logic signed [DATA_W-1:0] angle_left_s3;
	logic signed [DATA_W-1:0] angle_right_s3;
	logic signed [DATA_W-1:0] pos_x_s3;
	logic signed [DATA_W-1:0] pos_y_s3;
	logic                     load_s2;
	logic                     load_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_left_q  <= '0;
			offset_right_q <= '0;
			gain_q         <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OFFSET_LEFT:   offset_left_q  <= cfg_data;
				REG_OFFSET_RIGHT:  offset_right_q <= cfg_data;
				REG_POSITION_GAIN: gain_q         <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign adv_s3  = !v_s3 || out_ready;
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;
	assign load_s2 = adv_s2 && v_s1;
	assign load_s3 = adv_s3 && v_s2;

	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			raw_left_s1  <= raw_left;
			raw_right_s1 <= raw_right;
		end
		if (load_s3) begin
			angle_left_s3  <= angle_left_s2;
			angle_right_s3 <= angle_right_s2;
		end
	end

	mtxy_track #(
		.ENCODER_BITS (ENCODER_BITS),
		.TURN_BITS    (TURN_BITS)
	) u_track_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_s2),
		.raw      (raw_left_s1),
		.offset   (offset_left_q),
		.angle_s2 (angle_left_s2)
	);

	mtxy_track #(
		.ENCODER_BITS (ENCODER_BITS),
		.TURN_BITS    (TURN_BITS)
	) u_track_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_s2),
		.raw      (raw_right_s1),
		.offset   (offset_right_q),
		.angle_s2 (angle_right_s2)
	);

	mtxy_mix u_mix (
		.clk         (clk),
		.load        (load_s3),
		.angle_left  (angle_left_s2),
		.angle_right (angle_right_s2),
		.gain        (gain_q),
		.pos_x_s3    (pos_x_s3),
		.pos_y_s3    (pos_y_s3)
	);

	assign out_valid   = v_s3;
	assign angle_left  = angle_left_s3;
	assign angle_right = angle_right_s3;
	assign pos_x       = pos_x_s3;
	assign pos_y       = pos_y_s3;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multiturn_encoder_xy_tracker. A queue of encoder
// reading pairs feeds a valid/ready driver, and a clocked monitor compares
// each output transfer with a predicted sample. The prediction tracks turns,
// offsets and gain on its own. Phases change the register settings while
// the block is idle and vary the idling on both channels. A steady sweep
// runs the two turn counters in opposite directions.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtxy_pkg::*;

	localparam int ENC = ENCODER_BITS_DEF;
	localparam int ENC_MASK = (1 << ENC) - 1;
	localparam int HALF_TURN = 1 << (ENC - 1);
	localparam int TURN_LIM = (1 << (TURN_BITS_DEF - 1)) - 1;
	localparam longint TURN_SPAN = longint'(1) << ENC;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SWEEP_LEN = 60;

	typedef struct packed {
		logic [ENC-1:0] raw_left;
		logic [ENC-1:0] raw_right;
	} encoder_pair_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] angle_left;
		logic signed [DATA_W-1:0] angle_right;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
	} motion_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ENC-1:0] raw_left = '0;
	logic [ENC-1:0] raw_right = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] angle_left;
	logic signed [DATA_W-1:0] angle_right;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;

	encoder_pair_t reading_q[$];
	motion_sample_t expected_samples[$];
	encoder_pair_t next_pair;
	motion_sample_t want_sample;

	// tracker shadow: state and registers
	logic [ENC-1:0] prev_rd[2];
	int turn_cnt[2];
	longint offset_cfg[2];
	logic [GAIN_W-1:0] gain_cfg;

	int gen_prev[2];
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int fail_count = 0;
	int hold_left;
	int hold_mark;
	int xfer_total;

	multiturn_encoder_xy_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_left   (raw_left),
		.raw_right  (raw_right),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.angle_left (angle_left),
		.angle_right(angle_right),
		.pos_x      (pos_x),
		.pos_y      (pos_y)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > longint'(SAT_MAX))
			return longint'(SAT_MAX);
		if (v < longint'(SAT_MIN))
			return longint'(SAT_MIN);
		return v;
	endfunction

	function automatic longint unwrap_angle(input int m, input logic [ENC-1:0] rd);
		logic [ENC-1:0] p;
		longint a;
		p = prev_rd[m];
		if (rd > p && int'(rd) - int'(p) > HALF_TURN) begin
			if (turn_cnt[m] < TURN_LIM)
				turn_cnt[m]++;
		end else if (p > rd && int'(p) - int'(rd) > HALF_TURN) begin
			if (turn_cnt[m] > -TURN_LIM)
				turn_cnt[m]--;
		end
		prev_rd[m] = rd;
		a = longint'(turn_cnt[m]) * TURN_SPAN - longint'(rd) + offset_cfg[m];
		return clamp32(a);
	endfunction

	function automatic motion_sample_t predict_sample(input logic [ENC-1:0] l,
		input logic [ENC-1:0] r);
		longint al, ar, dx, dy, g, px, py;
		motion_sample_t s;
		al = unwrap_angle(0, l);
		ar = unwrap_angle(1, r);
		g = longint'(gain_cfg);
		dx = al - ar;
		dy = -al - ar;
		px = clamp32((dx * g) >>> GAIN_SHIFT);
		py = clamp32((dy * g) >>> GAIN_SHIFT);
		s.angle_left = al[DATA_W-1:0];
		s.angle_right = ar[DATA_W-1:0];
		s.pos_x = px[DATA_W-1:0];
		s.pos_y = py[DATA_W-1:0];
		return s;
	endfunction

	task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
		input logic signed [DATA_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// input channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			raw_left <= '0;
			raw_right <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_samples.push_back(predict_sample(raw_left, raw_right));
			if (!in_valid || in_ready) begin
				if (reading_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_pair = reading_q.pop_front();
					in_valid <= 1'b1;
					raw_left <= next_pair.raw_left;
					raw_right <= next_pair.raw_right;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					fail_count++;
					$error("output transfer with no sample expected");
				end else begin
					want_sample = expected_samples.pop_front();
					check_field("angle_left", want_sample.angle_left, angle_left);
					check_field("angle_right", want_sample.angle_right, angle_right);
					check_field("pos_x", want_sample.pos_x, pos_x);
					check_field("pos_y", want_sample.pos_y, pos_y);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// long receiver hold-off after 300 output transfers and every 900 after that
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_mark <= 300;
			xfer_total <= 0;
		end else begin
			if (out_valid && out_ready)
				xfer_total <= xfer_total + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (xfer_total >= hold_mark) begin
				hold_left <= 64;
				hold_mark <= hold_mark + 900;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_OFFSET_LEFT: offset_cfg[0] = $signed(val);
			REG_OFFSET_RIGHT: offset_cfg[1] = $signed(val);
			REG_POSITION_GAIN: gain_cfg = val[GAIN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_reading(input int l, input int r);
		encoder_pair_t pr;
		pr.raw_left = l[ENC-1:0];
		pr.raw_right = r[ENC-1:0];
		reading_q.push_back(pr);
		gen_prev[0] = l & ENC_MASK;
		gen_prev[1] = r & ENC_MASK;
	endtask

	// smooth motion most often, with half-turn jumps, wild values, full-scale or zero readings and stops
	function automatic int next_reading(input int prev);
		int k;
		int delta;
		k = $urandom_range(99);
		if (k < 45) begin
			delta = $urandom_range(600);
			return (prev + delta - 300) & ENC_MASK;
		end else if (k < 65) begin
			delta = $urandom_range(HALF_TURN + 1, HALF_TURN - 1);
			return ($urandom_range(1) ? prev + delta : prev - delta) & ENC_MASK;
		end else if (k < 85) begin
			return $urandom_range(ENC_MASK);
		end else if (k < 93) begin
			return $urandom_range(1) ? ENC_MASK : 0;
		end
		return prev;
	endfunction

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			push_reading(next_reading(gen_prev[0]), next_reading(gen_prev[1]));
	endtask

	task automatic wait_drained();
		while (reading_q.size() != 0 || in_valid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		prev_rd[0] = '0;
		prev_rd[1] = '0;
		turn_cnt[0] = 0;
		turn_cnt[1] = 0;
		offset_cfg[0] = 0;
		offset_cfg[1] = 0;
		gain_cfg = GAIN_RESET;
		gen_prev[0] = 0;
		gen_prev[1] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, receiver mostly stalled
		sender_idle_pct = 19;
		receiver_idle_pct = 72;
		push_reading(HALF_TURN, HALF_TURN + 1);
		push_reading(0, 0);
		push_reading(ENC_MASK, ENC_MASK);
		push_reading(0, 0);
		push_reading(0, ENC_MASK);
		push_reading(ENC_MASK, 0);
		push_reading(HALF_TURN - 1, HALF_TURN - 1);
		push_reading(0, ENC_MASK);
		push_reading(HALF_TURN + 1, HALF_TURN - 2);
		push_reading(10922, 5461);
		push_reading(5461, 10922);
		push_reading(ENC_MASK, ENC_MASK);
		push_reading(0, 0);
		push_random(580);
		wait_drained();

		// offsets at the extremes, full gain, sender mostly idle
		write_reg(REG_OFFSET_LEFT, 32'h7fff_ffff);
		write_reg(REG_OFFSET_RIGHT, 32'h8000_0000);
		write_reg(REG_POSITION_GAIN, 32'hffff_ffff);
		write_reg(REG_UNUSED, $urandom);
		sender_idle_pct = 72;
		receiver_idle_pct = 19;
		push_reading(0, ENC_MASK);
		push_reading(ENC_MASK, 0);
		push_reading(HALF_TURN + 1, 1);
		push_reading(0, 0);
		push_reading(ENC_MASK, ENC_MASK);
		push_reading(1, HALF_TURN + 2);
		push_random(550);
		wait_drained();

		// swapped extremes, zero gain, no random idling from here on
		write_reg(REG_OFFSET_LEFT, 32'h8000_0000);
		write_reg(REG_OFFSET_RIGHT, 32'h7fff_ffff);
		write_reg(REG_POSITION_GAIN, 32'hab00_0000);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		push_random(200);
		wait_drained();

		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_POSITION_GAIN, $urandom);
		write_reg(REG_OFFSET_RIGHT, $urandom);
		write_reg(REG_OFFSET_LEFT, $urandom);
		push_random(400);
		wait_drained();

		// steady rotation: left counts up and right counts down
		write_reg(REG_OFFSET_LEFT, 32'd0);
		write_reg(REG_OFFSET_RIGHT, 32'd0);
		write_reg(REG_POSITION_GAIN, {8'h00, 24'($urandom)});
		for (int i = 0; i < SWEEP_LEN; i++)
			push_reading(gen_prev[0] + HALF_TURN + 1, gen_prev[1] + HALF_TURN - 1);
		push_random(40);
		wait_drained();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("multiturn_encoder_xy_tracker regression: pass");
		else
			$display("multiturn_encoder_xy_tracker regression: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("multiturn_encoder_xy_tracker regression: fail");
		$finish;
	end

endmodule
